// ===== rtl/mtlv_pkg.sv =====
// Package for the metric TLV part decoder: sizes, phase codes, result kinds
// and the result record type. No dependencies.
package mtlv_pkg;
    localparam int MAX_VALUES = 16;
    localparam int TYPE_AW    = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_STRING = 3'd1;
    localparam logic [2:0] PH_TIME   = 3'd2;
    localparam logic [2:0] PH_COUNT  = 3'd3;
    localparam logic [2:0] PH_TYPES  = 3'd4;
    localparam logic [2:0] PH_VALUES = 3'd5;
    localparam logic [2:0] PH_SKIP   = 3'd6;

    localparam logic [2:0] K_STRING = 3'd0;
    localparam logic [2:0] K_TIME   = 3'd1;
    localparam logic [2:0] K_VALUE  = 3'd2;
    localparam logic [2:0] K_COMMIT = 3'd3;
    localparam logic [2:0] K_DONE   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_PARSE = 2'd2;

    localparam logic [1:0] VT_GAUGE = 2'd1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  string_field;
        logic [63:0] payload;
        logic        string_end;
        logic        time_hires;
        logic [5:0]  value_index;
        logic [1:0]  value_type;
        logic [15:0] value_count;
        logic [1:0]  status;
        logic        last;
    } t_result;
endpackage

// ===== rtl/metric_tlv_part_decoder.sv =====
// Top level of the metric TLV part decoder: byte parser, type store memory
// and a four-entry result queue. Depends on mtlv_pkg.
//
//  channel | valid   | stall   | fields
//  input   | i_valid | o_stall | i_action, i_msg_byte
//  output  | o_valid | i_stall | o_kind .. o_last
//
// One byte is taken every cycle while o_stall is low; each byte is parsed in the cycle it is taken.
// An item gives at most two results, which enter the result queue at once.
// Input stalls while more than two queue entries are occupied.
// The type store is a 16-entry memory with a registered read, addressed ahead by the next index, with write forwarding.
// Synchronous reset clears the parser and the queue; no clearing pass is needed.
module metric_tlv_part_decoder
    import mtlv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [7:0]  i_msg_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [2:0]  o_string_field,
    output logic [63:0] o_payload,
    output logic        o_string_end,
    output logic        o_time_hires,
    output logic [5:0]  o_value_index,
    output logic [1:0]  o_value_type,
    output logic [15:0] o_value_count,
    output logic [1:0]  o_status,
    output logic        o_last
);
    logic [2:0]  r_phase, n_phase;
    logic [1:0]  r_hcnt, n_hcnt;
    logic [15:0] r_pkind, n_pkind;
    logic [15:0] r_left, n_left;
    logic [15:0] r_decl, n_decl;
    logic [15:0] r_cur, n_cur;
    logic [2:0]  r_biw, n_biw;
    logic [63:0] r_word, n_word;
    logic [1:0]  r_err, n_err;

    logic [1:0]  mem [MAX_VALUES];
    logic [1:0]  r_type;
    logic        we;
    logic [TYPE_AW-1:0] waddr, raddr;
    logic [1:0]  wdata;

    t_result     r_fifo [4];
    logic [1:0]  r_head, r_tail;
    logic [2:0]  r_count;
    t_result     res0, res1;
    logic        v0, v1;
    logic        accept, pop;

    logic        kept;
    logic [1:0]  vt;
    logic [15:0] len;
    logic [15:0] cur1;
    logic [7:0]  b;

    assign accept = i_valid && !o_stall;
    assign o_stall = r_count > 3'd2;
    assign pop = (r_count != 3'd0) && !i_stall;
    assign b = i_msg_byte;

    always_comb begin
        n_phase = r_phase; n_hcnt = r_hcnt; n_pkind = r_pkind; n_left = r_left;
        n_decl = r_decl; n_cur = r_cur; n_biw = r_biw; n_word = r_word; n_err = r_err;
        res0 = '0; res1 = '0; v0 = 1'b0; v1 = 1'b0;
        we = 1'b0; waddr = r_cur[TYPE_AW-1:0]; wdata = b[1:0];
        kept = r_cur < 16'(MAX_VALUES);
        vt = kept ? r_type : 2'd0;
        len = {r_left[7:0], b};
        cur1 = r_cur + 16'd1;
        if (accept) begin
            if (i_action) begin
                v0 = 1'b1;
                res0.kind = K_DONE;
                res0.status = (r_err != ST_OK) ? r_err :
                    ((r_phase != PH_HEADER || r_hcnt != 2'd0) ? ST_SHORT : ST_OK);
                n_phase = PH_HEADER; n_hcnt = '0; n_pkind = '0; n_left = '0;
                n_decl = '0; n_cur = '0; n_biw = '0; n_word = '0; n_err = ST_OK;
            end else if (r_err == ST_OK) begin
                unique case (r_phase)
                    PH_HEADER: begin
                        if (r_hcnt < 2'd2) n_pkind = {r_pkind[7:0], b};
                        else n_left = len;
                        if (r_hcnt == 2'd3) begin
                            n_hcnt = '0;
                            if (len < 16'd4) begin
                                n_err = ST_PARSE; n_phase = PH_HEADER;
                            end else begin
                                n_left = len - 16'd4;
                                n_biw = '0; n_word = '0; n_cur = '0; n_decl = '0;
                                priority if (r_pkind == 16'd0 || r_pkind == 16'd2 ||
                                    r_pkind == 16'd3 || r_pkind == 16'd4 ||
                                    r_pkind == 16'd5) begin
                                    if (n_left == 16'd0) n_err = ST_PARSE;
                                    else n_phase = PH_STRING;
                                end else if (r_pkind == 16'd1 || r_pkind == 16'd8) begin
                                    if (n_left != 16'd8) n_err = ST_PARSE;
                                    else n_phase = PH_TIME;
                                end else if (r_pkind == 16'd6) begin
                                    if (n_left < 16'd2) n_err = ST_PARSE;
                                    else n_phase = PH_COUNT;
                                end else begin
                                    n_phase = (n_left != 16'd0) ? PH_SKIP : PH_HEADER;
                                end
                            end
                        end else begin
                            n_hcnt = r_hcnt + 2'd1;
                        end
                    end
                    PH_STRING: begin
                        res0.kind = K_STRING;
                        res0.string_field = (r_pkind == 16'd0) ? 3'd0 : 3'(r_pkind - 16'd1);
                        n_left = r_left - 16'd1;
                        if (n_left == 16'd0) begin
                            if (b == 8'd0) begin
                                v0 = 1'b1; res0.string_end = 1'b1;
                                n_phase = PH_HEADER;
                            end else begin
                                n_err = ST_PARSE; n_phase = PH_HEADER;
                            end
                        end else begin
                            v0 = 1'b1; res0.payload = {56'd0, b};
                        end
                    end
                    PH_TIME: begin
                        n_word = {r_word[55:0], b};
                        if (r_biw == 3'd7) begin
                            v0 = 1'b1; res0.kind = K_TIME; res0.payload = n_word;
                            res0.time_hires = (r_pkind == 16'd8);
                            n_biw = '0; n_word = '0; n_phase = PH_HEADER;
                        end else begin
                            n_biw = r_biw + 3'd1;
                        end
                    end
                    PH_COUNT: begin
                        n_decl = {r_decl[7:0], b};
                        if (r_biw == 3'd0) begin
                            n_biw = 3'd1;
                        end else begin
                            n_biw = '0;
                            n_left = r_left - 16'd2;
                            if ({4'd0, n_left} != {4'd0, n_decl} * 20'd9) begin
                                n_err = ST_PARSE; n_phase = PH_HEADER;
                            end else if (n_decl == 16'd0) begin
                                v0 = 1'b1; res0.kind = K_COMMIT; n_phase = PH_HEADER;
                            end else begin
                                n_cur = '0; n_phase = PH_TYPES;
                            end
                        end
                    end
                    PH_TYPES: begin
                        if (kept && b > 8'd3) begin
                            n_err = ST_PARSE; n_phase = PH_HEADER;
                        end else begin
                            we = kept;
                            n_cur = cur1;
                            if (cur1 == r_decl) begin
                                n_cur = '0; n_biw = '0; n_word = '0; n_phase = PH_VALUES;
                            end
                        end
                    end
                    PH_VALUES: begin
                        if (vt == VT_GAUGE) n_word = r_word | ({56'd0, b} << {r_biw, 3'd0});
                        else n_word = {r_word[55:0], b};
                        if (r_biw != 3'd7) begin
                            n_biw = r_biw + 3'd1;
                        end else begin
                            v0 = kept;
                            res0.kind = K_VALUE; res0.payload = n_word;
                            res0.value_index = r_cur[5:0]; res0.value_type = vt;
                            n_cur = cur1; n_biw = '0; n_word = '0;
                            if (cur1 == r_decl) begin
                                n_phase = PH_HEADER;
                                if (kept) begin
                                    v1 = 1'b1; res1.kind = K_COMMIT;
                                    res1.value_count = r_decl;
                                end else begin
                                    v0 = 1'b1; res0 = '0; res0.kind = K_COMMIT;
                                    res0.value_count = r_decl;
                                end
                            end
                        end
                    end
                    PH_SKIP: begin
                        n_left = r_left - 16'd1;
                        if (n_left == 16'd0) n_phase = PH_HEADER;
                    end
                    default: n_phase = PH_HEADER;
                endcase
            end
        end
        if (v1) res1.last = 1'b1;
        else res0.last = v0;
        raddr = n_cur[TYPE_AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (we && waddr == raddr) r_type <= wdata;
        else r_type <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_hcnt <= '0; r_pkind <= '0; r_left <= '0;
            r_decl <= '0; r_cur <= '0; r_biw <= '0; r_word <= '0; r_err <= ST_OK;
            r_head <= '0; r_tail <= '0; r_count <= '0;
        end else begin
            r_phase <= n_phase; r_hcnt <= n_hcnt; r_pkind <= n_pkind; r_left <= n_left;
            r_decl <= n_decl; r_cur <= n_cur; r_biw <= n_biw; r_word <= n_word;
            r_err <= n_err;
            if (pop) r_head <= r_head + 2'd1;
            r_tail <= r_tail + 2'(v0) + 2'(v1);
            r_count <= r_count + 3'(v0) + 3'(v1) - 3'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (v0) r_fifo[r_tail] <= res0;
        if (v1) r_fifo[r_tail + 2'd1] <= res1;
    end

    assign o_valid        = r_count != 3'd0;
    assign o_kind         = r_fifo[r_head].kind;
    assign o_string_field = r_fifo[r_head].string_field;
    assign o_payload      = r_fifo[r_head].payload;
    assign o_string_end   = r_fifo[r_head].string_end;
    assign o_time_hires   = r_fifo[r_head].time_hires;
    assign o_value_index  = r_fifo[r_head].value_index;
    assign o_value_type   = r_fifo[r_head].value_type;
    assign o_value_count  = r_fifo[r_head].value_count;
    assign o_status       = r_fifo[r_head].status;
    assign o_last         = r_fifo[r_head].last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4) else $error("result queue overflow");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_action |=> r_phase == PH_HEADER && r_err == ST_OK && r_hcnt == 2'd0)
        else $error("end of message did not clear parser");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == K_DONE |-> o_last)
        else $error("done result without last");
endmodule
